// File: hw/rtl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg: shared types and constants of the epoch seconds calendar converter
// Holds the datapath widths, the sequencer states, the request and response
// structs of the shared arithmetic unit and the Gregorian calendar helpers.
// ----------------------------------------------------------------------------
package esc_pkg;

  // Datapath widths.
  localparam int ACC_W = 38;  // running remainder / packed seconds
  localparam int OPD_W = 20;  // second operand of the shared unit
  localparam int SUM_W = 20;  // day accumulator
  localparam int Q_W   = 20;  // quotient shift register
  localparam int CNT_W = 5;   // bit index / loop counter

  // Calendar constants.
  localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
  localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
  localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
  localparam logic [11:0] CENT_BASE     = 12'd1901;
  localparam logic [11:0] QUAD_BASE     = 12'd1601;
  localparam logic [6:0]  CENT_LEN      = 7'd100;
  localparam logic [8:0]  QUAD_LEN      = 9'd400;
  localparam logic [2:0]  WEEK_LEN      = 3'd7;
  localparam logic [2:0]  EPOCH_WDAY    = 3'd4;   // 1970-01-01 was a Thursday
  localparam logic [3:0]  LAST_MONTH    = 4'd11;

  // Year position of 1970 inside the four, hundred and four-hundred year cycles.
  localparam logic [1:0] EPOCH_MOD4   = 2'd2;
  localparam logic [6:0] EPOCH_MOD100 = 7'd70;
  localparam logic [8:0] EPOCH_MOD400 = 9'd370;

  // Top bit index of each shift-and-subtract or shift-and-add loop.
  localparam logic [CNT_W-1:0] DAY_TOP  = 5'd15;  // seconds / 86400, 16 quotient bits
  localparam logic [CNT_W-1:0] HOUR_TOP = 5'd4;   // remainder / 3600
  localparam logic [CNT_W-1:0] MIN_TOP  = 5'd5;   // remainder / 60
  localparam logic [CNT_W-1:0] WK0_TOP  = 5'd12;  // (days + 4) mod 7, decode side
  localparam logic [CNT_W-1:0] C100_TOP = 5'd4;   // century count
  localparam logic [CNT_W-1:0] C400_TOP = 5'd2;   // four-century count
  localparam logic [CNT_W-1:0] YMUL_TOP = 5'd8;   // years times 365
  localparam logic [CNT_W-1:0] DMUL_TOP = 5'd16;  // days times 86400
  localparam logic [CNT_W-1:0] HMUL_TOP = 5'd11;  // hours times 3600
  localparam logic [CNT_W-1:0] MMUL_TOP = 5'd5;   // minutes times 60
  localparam logic [CNT_W-1:0] TOT_TOP  = 5'd19;  // total / 86400, 20 quotient bits
  localparam logic [CNT_W-1:0] WK1_TOP  = 5'd17;  // (days + 4) mod 7, encode side

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    ALU_ADD,  // a + (b << sh)
    ALU_SUB,  // a - (b << sh)
    ALU_TRY   // a - (b << sh) if that does not go negative, else a
  } alu_op_t;

  typedef struct packed {
    alu_op_t              op;
    logic [ACC_W-1:0]     a;
    logic [OPD_W-1:0]     b;
    logic [CNT_W-1:0]     sh;
  } alu_req_t;

  typedef struct packed {
    logic [ACC_W-1:0] res;
    logic             ge;
  } alu_rsp_t;

  // One input beat.
  typedef struct packed {
    logic        command;
    logic [31:0] seconds;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } item_t;

  // Finished result from the sequencer, valid while done is high.
  typedef struct packed {
    logic        done;
    logic        command;
    logic [31:0] seconds;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic        overflow;
  } result_t;

  // Command codes.
  localparam logic CMD_SPLIT = 1'b0;
  localparam logic CMD_PACK  = 1'b1;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    // seconds to calendar
    ST_D_DAY, ST_D_HOUR, ST_D_MIN, ST_W0_LD, ST_D_W0, ST_YEAR, ST_MONTH,
    // calendar to seconds
    ST_L100, ST_D100, ST_L400, ST_D400, ST_L1970, ST_M365, ST_INC, ST_A4,
    ST_S100, ST_A400, ST_MON1, ST_ADAY, ST_SUB1, ST_MDAY, ST_MHR, ST_MMIN,
    ST_ASEC, ST_D_TOT, ST_W1_LD, ST_D_W1,
    // result handoff
    ST_FIN
  } state_t;

  // Length of a year in days.
  function automatic logic [8:0] year_len(input logic leap);
    year_len = leap ? 9'd366 : 9'd365;
  endfunction

  // Length of a month in days, month 0 is January.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] d;
    unique case (m) inside
      4'd1:                    d = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
      default:                 d = 5'd31;
    endcase
    month_len = d;
  endfunction

endpackage

// File: hw/rtl/esc_alu.sv
// ----------------------------------------------------------------------------
// esc_alu: shared shift, add and trial-subtract unit
// An adder and a subtractor, whose borrow is the compare, on the shifted
// second operand; every division, multiplication and calendar walk runs on it.
// ----------------------------------------------------------------------------
module esc_alu (
  input  esc_pkg::alu_req_t req,
  output esc_pkg::alu_rsp_t rsp
);

  logic [esc_pkg::ACC_W-1:0] b_sh;
  logic [esc_pkg::ACC_W:0]   diff;

  // Shift the operand and form the difference with its borrow.
  always_comb begin
    b_sh = esc_pkg::ACC_W'(req.b) << req.sh;
    diff = {1'b0, req.a} - {1'b0, b_sh};
  end

  // Select the result of the requested operation.
  always_comb begin
    rsp.ge = ~diff[esc_pkg::ACC_W];
    unique case (req.op)
      esc_pkg::ALU_ADD: rsp.res = req.a + b_sh;
      esc_pkg::ALU_SUB: rsp.res = diff[esc_pkg::ACC_W-1:0];
      esc_pkg::ALU_TRY: rsp.res = rsp.ge ? diff[esc_pkg::ACC_W-1:0] : req.a;
      default:          rsp.res = req.a;
    endcase
  end

endmodule

// File: hw/rtl/esc_seq.sv
// ----------------------------------------------------------------------------
// esc_seq: conversion sequencer and working registers
// Steps the shared unit through restoring divisions, constant shift-and-add
// multiplications and the year and month walks, one step per cycle.
// ----------------------------------------------------------------------------
module esc_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  esc_pkg::item_t    item,
  output logic              busy,
  output esc_pkg::alu_req_t alu_req,
  input  esc_pkg::alu_rsp_t alu_rsp,
  output esc_pkg::result_t  result
);

  esc_pkg::state_t           state_r, state_nxt;
  logic [esc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      cmd_r, cmd_nxt;
  logic [esc_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [esc_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [esc_pkg::Q_W-1:0]   q_r, q_nxt;
  logic [11:0]               year_r, year_nxt;
  logic [3:0]                mon_r, mon_nxt;
  logic [4:0]                day_r, day_nxt;
  logic [4:0]                hr_r, hr_nxt;
  logic [5:0]                mn_r, mn_nxt;
  logic [5:0]                sc_r, sc_nxt;
  logic [2:0]                wd_r, wd_nxt;
  logic [31:0]               secs_r, secs_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [1:0]                m4_r, m4_nxt;
  logic [6:0]                m100_r, m100_nxt;
  logic [8:0]                m400_r, m400_nxt;
  logic                      cent_r, cent_nxt;
  logic                      quad_r, quad_nxt;
  logic [4:0]                q100_r, q100_nxt;
  logic [2:0]                q400_r, q400_nxt;

  logic                      last;
  logic                      leap;
  logic [esc_pkg::Q_W-1:0]   q_fin;

  // Leap flag: walked counters when decoding, remainders of the century
  // divisions when encoding.
  always_comb begin
    if (cmd_r == esc_pkg::CMD_PACK) begin
      leap = (year_r[1:0] == 2'd0) && (!cent_r || quad_r);
    end else begin
      leap = (m4_r == 2'd0) && ((m100_r != 7'd0) || (m400_r == 9'd0));
    end
    last  = (cnt_r == '0);
    q_fin = {q_r[esc_pkg::Q_W-2:0], alu_rsp.ge};
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= esc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    cmd_r  <= cmd_nxt;
    acc_r  <= acc_nxt;
    sum_r  <= sum_nxt;
    q_r    <= q_nxt;
    year_r <= year_nxt;
    mon_r  <= mon_nxt;
    day_r  <= day_nxt;
    hr_r   <= hr_nxt;
    mn_r   <= mn_nxt;
    sc_r   <= sc_nxt;
    wd_r   <= wd_nxt;
    secs_r <= secs_nxt;
    ovf_r  <= ovf_nxt;
    m4_r   <= m4_nxt;
    m100_r <= m100_nxt;
    m400_r <= m400_nxt;
    cent_r <= cent_nxt;
    quad_r <= quad_nxt;
    q100_r <= q100_nxt;
    q400_r <= q400_nxt;
  end

  // Next state, shared unit request and register updates.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd_nxt   = cmd_r;
    acc_nxt   = acc_r;
    sum_nxt   = sum_r;
    q_nxt     = q_r;
    year_nxt  = year_r;
    mon_nxt   = mon_r;
    day_nxt   = day_r;
    hr_nxt    = hr_r;
    mn_nxt    = mn_r;
    sc_nxt    = sc_r;
    wd_nxt    = wd_r;
    secs_nxt  = secs_r;
    ovf_nxt   = ovf_r;
    m4_nxt    = m4_r;
    m100_nxt  = m100_r;
    m400_nxt  = m400_r;
    cent_nxt  = cent_r;
    quad_nxt  = quad_r;
    q100_nxt  = q100_r;
    q400_nxt  = q400_r;

    alu_req.op = esc_pkg::ALU_TRY;
    alu_req.a  = acc_r;
    alu_req.b  = '0;
    alu_req.sh = cnt_r;

    unique case (state_r)
      esc_pkg::ST_IDLE: begin
        if (start) begin
          cmd_nxt = item.command;
          q_nxt   = '0;
          if (item.command == esc_pkg::CMD_SPLIT) begin
            acc_nxt   = esc_pkg::ACC_W'(item.seconds);
            secs_nxt  = item.seconds;
            ovf_nxt   = 1'b0;
            year_nxt  = esc_pkg::EPOCH_YEAR;
            mon_nxt   = 4'd0;
            m4_nxt    = esc_pkg::EPOCH_MOD4;
            m100_nxt  = esc_pkg::EPOCH_MOD100;
            m400_nxt  = esc_pkg::EPOCH_MOD400;
            cnt_nxt   = esc_pkg::DAY_TOP;
            state_nxt = esc_pkg::ST_D_DAY;
          end else begin
            // A year before 1970 and a month past December are clamped; day 0 becomes 1.
            year_nxt  = (item.year < esc_pkg::EPOCH_YEAR) ? esc_pkg::EPOCH_YEAR : item.year;
            mon_nxt   = (item.month > esc_pkg::LAST_MONTH) ? esc_pkg::LAST_MONTH : item.month;
            day_nxt   = (item.day == 5'd0) ? 5'd1 : item.day;
            hr_nxt    = item.hour;
            mn_nxt    = item.minute;
            sc_nxt    = item.second;
            state_nxt = esc_pkg::ST_L100;
          end
        end
      end

      // ---- seconds to calendar ----
      esc_pkg::ST_D_DAY: begin
        alu_req.b = esc_pkg::OPD_W'(esc_pkg::SEC_PER_DAY);
        acc_nxt   = alu_rsp.res;
        q_nxt     = q_fin;
        cnt_nxt   = cnt_r - 1'b1;
        if (last) begin
          sum_nxt   = esc_pkg::SUM_W'(q_fin);
          q_nxt     = '0;
          cnt_nxt   = esc_pkg::HOUR_TOP;
          state_nxt = esc_pkg::ST_D_HOUR;
        end
      end

      esc_pkg::ST_D_HOUR: begin
        alu_req.b = esc_pkg::OPD_W'(esc_pkg::SEC_PER_HOUR);
        acc_nxt   = alu_rsp.res;
        q_nxt     = q_fin;
        cnt_nxt   = cnt_r - 1'b1;
        if (last) begin
          hr_nxt    = q_fin[4:0];
          q_nxt     = '0;
          cnt_nxt   = esc_pkg::MIN_TOP;
          state_nxt = esc_pkg::ST_D_MIN;
        end
      end

      esc_pkg::ST_D_MIN: begin
        alu_req.b = esc_pkg::OPD_W'(esc_pkg::SEC_PER_MIN);
        acc_nxt   = alu_rsp.res;
        q_nxt     = q_fin;
        cnt_nxt   = cnt_r - 1'b1;
        if (last) begin
          mn_nxt    = q_fin[5:0];
          sc_nxt    = alu_rsp.res[5:0];
          state_nxt = esc_pkg::ST_W0_LD;
        end
      end

      esc_pkg::ST_W0_LD: begin
        alu_req.op = esc_pkg::ALU_ADD;
        alu_req.a  = esc_pkg::ACC_W'(sum_r);
        alu_req.b  = esc_pkg::OPD_W'(esc_pkg::EPOCH_WDAY);
        alu_req.sh = '0;
        acc_nxt    = alu_rsp.res;
        cnt_nxt    = esc_pkg::WK0_TOP;
        state_nxt  = esc_pkg::ST_D_W0;
      end

      esc_pkg::ST_D_W0: begin
        alu_req.b = esc_pkg::OPD_W'(esc_pkg::WEEK_LEN);
        acc_nxt   = alu_rsp.res;
        cnt_nxt   = cnt_r - 1'b1;
        if (last) begin
          wd_nxt    = alu_rsp.res[2:0];
          state_nxt = esc_pkg::ST_YEAR;
        end
      end

      // Walk the years one per cycle.
      esc_pkg::ST_YEAR: begin
        alu_req.a  = esc_pkg::ACC_W'(sum_r);
        alu_req.b  = esc_pkg::OPD_W'(esc_pkg::year_len(leap));
        alu_req.sh = '0;
        if (alu_rsp.ge) begin
          sum_nxt  = alu_rsp.res[esc_pkg::SUM_W-1:0];
          year_nxt = year_r + 12'd1;
          m4_nxt   = m4_r + 2'd1;
          m100_nxt = (m100_r == esc_pkg::CENT_LEN - 7'd1) ? 7'd0 : m100_r + 7'd1;
          m400_nxt = (m400_r == esc_pkg::QUAD_LEN - 9'd1) ? 9'd0 : m400_r + 9'd1;
        end else begin
          state_nxt = esc_pkg::ST_MONTH;
        end
      end

      // Walk the months; December takes whatever days are left.
      esc_pkg::ST_MONTH: begin
        alu_req.a  = esc_pkg::ACC_W'(sum_r);
        alu_req.b  = esc_pkg::OPD_W'(esc_pkg::month_len(mon_r, leap));
        alu_req.sh = '0;
        if ((mon_r != esc_pkg::LAST_MONTH) && alu_rsp.ge) begin
          sum_nxt = alu_rsp.res[esc_pkg::SUM_W-1:0];
          mon_nxt = mon_r + 4'd1;
        end else begin
          day_nxt   = sum_r[4:0] + 5'd1;
          state_nxt = esc_pkg::ST_FIN;
        end
      end

      // ---- calendar to seconds ----
      esc_pkg::ST_L100: begin
        alu_req.op = esc_pkg::ALU_SUB;
        alu_req.a  = esc_pkg::ACC_W'(year_r);
        alu_req.b  = esc_pkg::OPD_W'(esc_pkg::CENT_BASE);
        alu_req.sh = '0;
        acc_nxt    = alu_rsp.res;
        q_nxt      = '0;
        cnt_nxt    = esc_pkg::C100_TOP;
        state_nxt  = esc_pkg::ST_D100;
      end

      esc_pkg::ST_D100: begin
        alu_req.b = esc_pkg::OPD_W'(esc_pkg::CENT_LEN);
        acc_nxt   = alu_rsp.res;
        q_nxt     = q_fin;
        cnt_nxt   = cnt_r - 1'b1;
        if (last) begin
          q100_nxt  = q_fin[4:0];
          // Remainder 99 of (year - 1901) means the year ends a century.
          cent_nxt  = (alu_rsp.res == esc_pkg::ACC_W'(esc_pkg::CENT_LEN - 7'd1));
          state_nxt = esc_pkg::ST_L400;
        end
      end

      esc_pkg::ST_L400: begin
        alu_req.op = esc_pkg::ALU_SUB;
        alu_req.a  = esc_pkg::ACC_W'(year_r);
        alu_req.b  = esc_pkg::OPD_W'(esc_pkg::QUAD_BASE);
        alu_req.sh = '0;
        acc_nxt    = alu_rsp.res;
        q_nxt      = '0;
        cnt_nxt    = esc_pkg::C400_TOP;
        state_nxt  = esc_pkg::ST_D400;
      end

      esc_pkg::ST_D400: begin
        alu_req.b = esc_pkg::OPD_W'(esc_pkg::QUAD_LEN);
        acc_nxt   = alu_rsp.res;
        q_nxt     = q_fin;
        cnt_nxt   = cnt_r - 1'b1;
        if (last) begin
          q400_nxt  = q_fin[2:0];
          quad_nxt  = (alu_rsp.res == esc_pkg::ACC_W'(esc_pkg::QUAD_LEN - 9'd1));
          state_nxt = esc_pkg::ST_L1970;
        end
      end

      esc_pkg::ST_L1970: begin
        alu_req.op = esc_pkg::ALU_SUB;
        alu_req.a  = esc_pkg::ACC_W'(year_r);
        alu_req.b  = esc_pkg::OPD_W'(esc_pkg::EPOCH_YEAR);
        alu_req.sh = '0;
        acc_nxt    = alu_rsp.res;
        cnt_nxt    = esc_pkg::YMUL_TOP;
        state_nxt  = esc_pkg::ST_M365;
      end

      // Whole years times 365, one constant bit per cycle.
      esc_pkg::ST_M365: begin
        alu_req.op = esc_pkg::ALU_ADD;
        alu_req.a  = (cnt_r == esc_pkg::YMUL_TOP) ? '0 : esc_pkg::ACC_W'(sum_r);
        alu_req.b  = acc_r[esc_pkg::OPD_W-1:0];
        if (esc_pkg::DAYS_PER_YEAR[cnt_r[3:0]]) begin
          sum_nxt = alu_rsp.res[esc_pkg::SUM_W-1:0];
        end
        cnt_nxt = cnt_r - 1'b1;
        if (last) begin
          state_nxt = esc_pkg::ST_INC;
        end
      end

      esc_pkg::ST_INC: begin
        alu_req.op = esc_pkg::ALU_ADD;
        alu_req.b  = esc_pkg::OPD_W'(1);
        alu_req.sh = '0;
        acc_nxt    = alu_rsp.res;
        state_nxt  = esc_pkg::ST_A4;
      end

      // Leap days of the four-year rule: (year - 1969) / 4.
      esc_pkg::ST_A4: begin
        alu_req.op = esc_pkg::ALU_ADD;
        alu_req.a  = esc_pkg::ACC_W'(sum_r);
        alu_req.b  = acc_r[esc_pkg::OPD_W+1:2];
        alu_req.sh = '0;
        sum_nxt    = alu_rsp.res[esc_pkg::SUM_W-1:0];
        state_nxt  = esc_pkg::ST_S100;
      end

      esc_pkg::ST_S100: begin
        alu_req.op = esc_pkg::ALU_SUB;
        alu_req.a  = esc_pkg::ACC_W'(sum_r);
        alu_req.b  = esc_pkg::OPD_W'(q100_r);
        alu_req.sh = '0;
        sum_nxt    = alu_rsp.res[esc_pkg::SUM_W-1:0];
        state_nxt  = esc_pkg::ST_A400;
      end

      esc_pkg::ST_A400: begin
        alu_req.op = esc_pkg::ALU_ADD;
        alu_req.a  = esc_pkg::ACC_W'(sum_r);
        alu_req.b  = esc_pkg::OPD_W'(q400_r);
        alu_req.sh = '0;
        sum_nxt    = alu_rsp.res[esc_pkg::SUM_W-1:0];
        cnt_nxt    = '0;
        state_nxt  = esc_pkg::ST_MON1;
      end

      // Add the lengths of the months before the given one.
      esc_pkg::ST_MON1: begin
        alu_req.op = esc_pkg::ALU_ADD;
        alu_req.a  = esc_pkg::ACC_W'(sum_r);
        alu_req.b  = esc_pkg::OPD_W'(esc_pkg::month_len(cnt_r[3:0], leap));
        alu_req.sh = '0;
        if (cnt_r[3:0] == mon_r) begin
          state_nxt = esc_pkg::ST_ADAY;
        end else begin
          sum_nxt = alu_rsp.res[esc_pkg::SUM_W-1:0];
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      esc_pkg::ST_ADAY: begin
        alu_req.op = esc_pkg::ALU_ADD;
        alu_req.a  = esc_pkg::ACC_W'(sum_r);
        alu_req.b  = esc_pkg::OPD_W'(day_r);
        alu_req.sh = '0;
        sum_nxt    = alu_rsp.res[esc_pkg::SUM_W-1:0];
        state_nxt  = esc_pkg::ST_SUB1;
      end

      esc_pkg::ST_SUB1: begin
        alu_req.op = esc_pkg::ALU_SUB;
        alu_req.a  = esc_pkg::ACC_W'(sum_r);
        alu_req.b  = esc_pkg::OPD_W'(1);
        alu_req.sh = '0;
        sum_nxt    = alu_rsp.res[esc_pkg::SUM_W-1:0];
        cnt_nxt    = esc_pkg::DMUL_TOP;
        state_nxt  = esc_pkg::ST_MDAY;
      end

      // Days times 86400 into the seconds accumulator.
      esc_pkg::ST_MDAY: begin
        alu_req.op = esc_pkg::ALU_ADD;
        alu_req.a  = (cnt_r == esc_pkg::DMUL_TOP) ? '0 : acc_r;
        alu_req.b  = esc_pkg::OPD_W'(sum_r);
        if (esc_pkg::SEC_PER_DAY[cnt_r]) begin
          acc_nxt = alu_rsp.res;
        end
        cnt_nxt = cnt_r - 1'b1;
        if (last) begin
          cnt_nxt   = esc_pkg::HMUL_TOP;
          state_nxt = esc_pkg::ST_MHR;
        end
      end

      esc_pkg::ST_MHR: begin
        alu_req.op = esc_pkg::ALU_ADD;
        alu_req.b  = esc_pkg::OPD_W'(hr_r);
        if (esc_pkg::SEC_PER_HOUR[cnt_r[3:0]]) begin
          acc_nxt = alu_rsp.res;
        end
        cnt_nxt = cnt_r - 1'b1;
        if (last) begin
          cnt_nxt   = esc_pkg::MMUL_TOP;
          state_nxt = esc_pkg::ST_MMIN;
        end
      end

      esc_pkg::ST_MMIN: begin
        alu_req.op = esc_pkg::ALU_ADD;
        alu_req.b  = esc_pkg::OPD_W'(mn_r);
        if (esc_pkg::SEC_PER_MIN[cnt_r[2:0]]) begin
          acc_nxt = alu_rsp.res;
        end
        cnt_nxt = cnt_r - 1'b1;
        if (last) begin
          state_nxt = esc_pkg::ST_ASEC;
        end
      end

      esc_pkg::ST_ASEC: begin
        alu_req.op = esc_pkg::ALU_ADD;
        alu_req.b  = esc_pkg::OPD_W'(sc_r);
        alu_req.sh = '0;
        acc_nxt    = alu_rsp.res;
        secs_nxt   = alu_rsp.res[31:0];
        ovf_nxt    = |alu_rsp.res[esc_pkg::ACC_W-1:32];
        q_nxt      = '0;
        cnt_nxt    = esc_pkg::TOT_TOP;
        state_nxt  = esc_pkg::ST_D_TOT;
      end

      // Day count of the exact total, for the weekday.
      esc_pkg::ST_D_TOT: begin
        alu_req.b = esc_pkg::OPD_W'(esc_pkg::SEC_PER_DAY);
        acc_nxt   = alu_rsp.res;
        q_nxt     = q_fin;
        cnt_nxt   = cnt_r - 1'b1;
        if (last) begin
          state_nxt = esc_pkg::ST_W1_LD;
        end
      end

      esc_pkg::ST_W1_LD: begin
        alu_req.op = esc_pkg::ALU_ADD;
        alu_req.a  = esc_pkg::ACC_W'(q_r);
        alu_req.b  = esc_pkg::OPD_W'(esc_pkg::EPOCH_WDAY);
        alu_req.sh = '0;
        acc_nxt    = alu_rsp.res;
        cnt_nxt    = esc_pkg::WK1_TOP;
        state_nxt  = esc_pkg::ST_D_W1;
      end

      esc_pkg::ST_D_W1: begin
        alu_req.b = esc_pkg::OPD_W'(esc_pkg::WEEK_LEN);
        acc_nxt   = alu_rsp.res;
        cnt_nxt   = cnt_r - 1'b1;
        if (last) begin
          wd_nxt    = alu_rsp.res[2:0];
          state_nxt = esc_pkg::ST_FIN;
        end
      end

      esc_pkg::ST_FIN: begin
        state_nxt = esc_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = esc_pkg::ST_IDLE;
      end
    endcase
  end

  // Status and finished fields.
  always_comb begin
    busy             = (state_r != esc_pkg::ST_IDLE);
    result.done      = (state_r == esc_pkg::ST_FIN);
    result.command   = cmd_r;
    result.seconds   = secs_r;
    result.year      = year_r;
    result.month     = mon_r;
    result.day       = day_r;
    result.hour      = hr_r;
    result.minute    = mn_r;
    result.second    = sc_r;
    result.weekday   = wd_r;
    result.overflow  = ovf_r;
  end

endmodule

// File: hw/rtl/epoch_seconds_calendar_converter.sv
// ----------------------------------------------------------------------------
// epoch_seconds_calendar_converter: seconds since 1970 <-> Gregorian calendar
// Splits a 32-bit seconds count into date, time and weekday, or packs date
// and time into seconds with weekday and an overflow flag.
// ----------------------------------------------------------------------------
// Usage:
//   An input beat is taken on a clock edge with start high and busy low;
//   in_command selects splitting (0) or packing (1). busy stays high while
//   the beat is converted. Its result is presented for exactly one cycle with
//   out_valid high; the receiver must take it then.
// Sequencing:
//   Splitting walks the years since 1970 and then the months; packing adds
//   the lengths of the months before the given one. All arithmetic runs
//   through a single shift, add and trial-subtract unit, one quotient bit,
//   one multiplier bit, one year or one month per cycle; one beat is in
//   flight at a time, and a new one may be started in the cycle its result
//   is shown.
// Reset:
//   rst_n returns the sequencer to idle and clears out_valid; no clearing
//   pass is needed.
// ----------------------------------------------------------------------------
module epoch_seconds_calendar_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [31:0] in_seconds_in,
  input  logic [11:0] in_year_in,
  input  logic [3:0]  in_month_in,
  input  logic [4:0]  in_day_in,
  input  logic [4:0]  in_hour_in,
  input  logic [5:0]  in_minute_in,
  input  logic [5:0]  in_second_in,
  output logic        out_valid,
  output logic [31:0] out_seconds_out,
  output logic [11:0] out_year_out,
  output logic [3:0]  out_month_out,
  output logic [4:0]  out_day_out,
  output logic [4:0]  out_hour_out,
  output logic [5:0]  out_minute_out,
  output logic [5:0]  out_second_out,
  output logic [2:0]  out_weekday,
  output logic        out_overflow
);

  esc_pkg::item_t    item;
  esc_pkg::alu_req_t alu_req;
  esc_pkg::alu_rsp_t alu_rsp;
  esc_pkg::result_t  result;
  logic              split;

  logic        out_valid_r;
  logic [31:0] seconds_r;
  logic [11:0] year_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r;
  logic [4:0]  hour_r;
  logic [5:0]  minute_r;
  logic [5:0]  second_r;
  logic [2:0]  weekday_r;
  logic        overflow_r;

  // Gather the input beat.
  always_comb begin
    item.command = in_command;
    item.seconds = in_seconds_in;
    item.year    = in_year_in;
    item.month   = in_month_in;
    item.day     = in_day_in;
    item.hour    = in_hour_in;
    item.minute  = in_minute_in;
    item.second  = in_second_in;
  end

  esc_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .item    (item),
    .busy    (busy),
    .alu_req (alu_req),
    .alu_rsp (alu_rsp),
    .result  (result)
  );

  esc_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= result.done;
    end
  end

  // Output register; fields that the command does not produce read as zero.
  assign split = (result.command == esc_pkg::CMD_SPLIT);

  always_ff @(posedge clk) begin
    if (result.done) begin
      seconds_r  <= result.seconds;
      year_r     <= split ? result.year   : 12'd0;
      month_r    <= split ? result.month  : 4'd0;
      day_r      <= split ? result.day    : 5'd0;
      hour_r     <= split ? result.hour   : 5'd0;
      minute_r   <= split ? result.minute : 6'd0;
      second_r   <= split ? result.second : 6'd0;
      weekday_r  <= result.weekday;
      overflow_r <= split ? 1'b0 : result.overflow;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_seconds_out = seconds_r;
  assign out_year_out    = year_r;
  assign out_month_out   = month_r;
  assign out_day_out     = day_r;
  assign out_hour_out    = hour_r;
  assign out_minute_out  = minute_r;
  assign out_second_out  = second_r;
  assign out_weekday     = weekday_r;
  assign out_overflow    = overflow_r;

  // An accepted beat keeps the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted beat");

  // Every result strobe lasts a single cycle.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("out_valid held for more than one cycle");

  // A result follows a busy period.
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result shown without a conversion in progress");

  // Overflow belongs to packing, whose calendar fields are zero.
  a_overflow_pack: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (out_year_out == 12'd0 && out_month_out == 4'd0))
    else $error("overflow raised on a split result");

endmodule
